FILE: design/bms_pkg.sv
// Shared types, constants and saturating fixed-point helpers of the body motion step unit.
`timescale 1ns / 1ps

package bms_pkg;

    localparam logic signed [31:0] S32_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN     = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE       = 32'sd65536;
    localparam logic signed [31:0] BOUNCE_STOP = 32'sd3277;
    localparam logic signed [31:0] SLIDE_STOP  = 32'sd9830;

    typedef enum logic [2:0] {
        IDX_GRAVITY      = 3'd0,
        IDX_RESTITUTION  = 3'd1,
        IDX_FRICTION     = 3'd2,
        IDX_FLOOR_LEVEL  = 3'd3,
        IDX_RECIP_WIDTH  = 3'd4,
        IDX_RECIP_HEIGHT = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [30:0]        gravity;
        logic [16:0]        restitution;
        logic [30:0]        friction;
        logic signed [31:0] floor_level;
        logic [16:0]        recip_width;
        logic [16:0]        recip_height;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [11:0]        size;
        logic               mv;
        logic               xm;
        logic               ym;
        logic [16:0]        dt;
    } body_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [16:0]        dt;
        logic signed [31:0] ground;
        logic signed [31:0] hi_x;
        logic signed [31:0] lo_x;
        logic signed [31:0] hi_y;
        logic signed [31:0] lo_y;
        logic signed [31:0] vx_fm;
        logic               fstop;
        logic               mv;
        logic               xm;
        logic               ym;
    } kin_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] hi_x;
        logic signed [31:0] lo_x;
        logic signed [31:0] hi_y;
        logic signed [31:0] lo_y;
        logic               mv;
        logic               xm;
        logic               ym;
    } flr_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               mv;
        logic               xm;
        logic               ym;
    } res_t;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? S32_MIN : S32_MAX;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        return sat33(s);
    endfunction

    function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic [32:0] s;
        s = {a[31], a} - {b[31], b};
        return sat33(s);
    endfunction

    // Q16.16 product scaling: drop sixteen fraction bits (floor) and saturate.
    function automatic logic signed [31:0] qmul_sat(input logic signed [63:0] p);
        logic [47:0] q;
        q = p[63:16];
        if (q[47:31] == {17{q[47]}}) begin
            return q[31:0];
        end
        return q[47] ? S32_MIN : S32_MAX;
    endfunction

    function automatic logic signed [32:0] neg33(input logic signed [31:0] v);
        return 33'd0 - {v[31], v};
    endfunction

endpackage

FILE: design/bms_kin.sv
// Kinematics stages: half sizes, gravity on vertical speed, horizontal integration, friction.
`timescale 1ns / 1ps

module bms_kin (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  bms_pkg::cfg_t  cfg,
    input  logic           in_vld,
    input  bms_pkg::body_t in_body,
    output logic           out_vld,
    output bms_pkg::kin_t  out_kin
);

    typedef struct packed {
        logic [28:0]        hw_p;
        logic [28:0]        hh_p;
        logic [47:0]        gdt_p;
        logic [47:0]        fdt_p;
        logic signed [49:0] vxdt_p;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [16:0]        dt;
        logic               mv;
        logic               xm;
        logic               ym;
    } k1_t;

    k1_t                k1_reg, k1_next;
    logic               k1_vld_reg;
    bms_pkg::kin_t      k2_reg, k2_next;
    logic               k2_vld_reg;
    logic signed [31:0] gq, vxq, dec;

    always_comb
    begin
        k1_next.hw_p   = in_body.size * cfg.recip_width;
        k1_next.hh_p   = in_body.size * cfg.recip_height;
        k1_next.gdt_p  = cfg.gravity * in_body.dt;
        k1_next.fdt_p  = cfg.friction * in_body.dt;
        k1_next.vxdt_p = $signed(in_body.vx) * $signed({1'b0, in_body.dt});
        k1_next.px     = in_body.px;
        k1_next.py     = in_body.py;
        k1_next.vx     = in_body.vx;
        k1_next.vy     = in_body.vy;
        k1_next.dt     = in_body.dt;
        k1_next.mv     = in_body.mv;
        k1_next.xm     = in_body.xm;
        k1_next.ym     = in_body.ym;
    end

    always_comb
    begin
        gq  = bms_pkg::qmul_sat({16'd0, k1_reg.gdt_p});
        vxq = bms_pkg::qmul_sat({{14{k1_reg.vxdt_p[49]}}, k1_reg.vxdt_p});
        dec = bms_pkg::qmul_sat({16'd0, k1_reg.fdt_p});

        k2_next.px = k1_reg.mv ? bms_pkg::add_sat(k1_reg.px, vxq) : k1_reg.px;
        k2_next.py = k1_reg.py;
        k2_next.vx = k1_reg.vx;
        k2_next.vy = k1_reg.mv ? bms_pkg::sub_sat(k1_reg.vy, gq) : k1_reg.vy;
        k2_next.dt = k1_reg.dt;
        k2_next.ground = bms_pkg::sat33({cfg.floor_level[31], cfg.floor_level}
                                        + {4'd0, k1_reg.hh_p});
        k2_next.hi_x = bms_pkg::Q_ONE - $signed({3'd0, k1_reg.hw_p});
        k2_next.lo_x = $signed({3'd0, k1_reg.hw_p}) - bms_pkg::Q_ONE;
        k2_next.hi_y = bms_pkg::Q_ONE - $signed({3'd0, k1_reg.hh_p});
        k2_next.lo_y = $signed({3'd0, k1_reg.hh_p}) - bms_pkg::Q_ONE;
        k2_next.vx_fm = ($signed(k1_reg.vx) > 32'sd0) ? bms_pkg::sub_sat(k1_reg.vx, dec)
                                                      : bms_pkg::add_sat(k1_reg.vx, dec);
        k2_next.fstop = ($signed(k2_next.vx_fm) >= -bms_pkg::SLIDE_STOP)
                     && ($signed(k2_next.vx_fm) <= bms_pkg::SLIDE_STOP);
        k2_next.mv = k1_reg.mv;
        k2_next.xm = k1_reg.xm;
        k2_next.ym = k1_reg.ym;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_reg <= k1_next;
            k2_reg <= k2_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_vld_reg <= 1'b0;
            k2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            k1_vld_reg <= in_vld;
            k2_vld_reg <= k1_vld_reg;
        end
    end

    assign out_vld = k2_vld_reg;
    assign out_kin = k2_reg;

endmodule

FILE: design/bms_floor.sv
// Floor stages: vertical integration, floor snap with bounce and ground friction.
`timescale 1ns / 1ps

module bms_floor (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  bms_pkg::cfg_t cfg,
    input  logic          in_vld,
    input  bms_pkg::kin_t in_kin,
    output logic          out_vld,
    output bms_pkg::flr_t out_flr
);

    typedef struct packed {
        logic signed [49:0] vydt_p;
        logic signed [50:0] bnc_p;
        bms_pkg::kin_t      k;
    } f3_t;

    typedef struct packed {
        logic signed [31:0] bval;
        logic               bstop;
        bms_pkg::kin_t      k;
    } f4_t;

    f3_t                f3_reg, f3_next;
    f4_t                f4_reg, f4_next;
    bms_pkg::kin_t      f5_reg, f5_next;
    bms_pkg::flr_t      f6_reg, f6_next;
    logic               f3_vld_reg, f4_vld_reg, f5_vld_reg, f6_vld_reg;
    logic signed [31:0] vyq;
    logic               hit, bounce, on_ground;

    always_comb
    begin
        f3_next.vydt_p = $signed(in_kin.vy) * $signed({1'b0, in_kin.dt});
        f3_next.bnc_p  = bms_pkg::neg33(in_kin.vy) * $signed({1'b0, cfg.restitution});
        f3_next.k      = in_kin;
    end

    always_comb
    begin
        vyq = bms_pkg::qmul_sat({{14{f3_reg.vydt_p[49]}}, f3_reg.vydt_p});
        f4_next.k = f3_reg.k;
        f4_next.k.py = f3_reg.k.mv ? bms_pkg::add_sat(f3_reg.k.py, vyq) : f3_reg.k.py;
        f4_next.bval = bms_pkg::qmul_sat({{13{f3_reg.bnc_p[50]}}, f3_reg.bnc_p});
        f4_next.bstop = ($signed(f4_next.bval) >= -bms_pkg::BOUNCE_STOP)
                     && ($signed(f4_next.bval) <= bms_pkg::BOUNCE_STOP);
    end

    always_comb
    begin
        hit    = f4_reg.k.mv && ($signed(f4_reg.k.py) < $signed(f4_reg.k.ground));
        bounce = hit && ($signed(f4_reg.k.vy) <= 32'sd0);
        f5_next = f4_reg.k;
        if (hit)
        begin
            f5_next.py = f4_reg.k.ground;
        end
        if (bounce)
        begin
            f5_next.vy = f4_reg.bstop ? 32'sd0 : f4_reg.bval;
            f5_next.ym = f4_reg.k.ym & ~f4_reg.bstop;
        end
    end

    always_comb
    begin
        on_ground = f5_reg.mv && (f5_reg.py == f5_reg.ground) && (f5_reg.vy == 32'sd0)
                 && (f5_reg.vx != 32'sd0);
        f6_next.px   = f5_reg.px;
        f6_next.py   = f5_reg.py;
        f6_next.vx   = f5_reg.vx;
        f6_next.vy   = f5_reg.vy;
        f6_next.hi_x = f5_reg.hi_x;
        f6_next.lo_x = f5_reg.lo_x;
        f6_next.hi_y = f5_reg.hi_y;
        f6_next.lo_y = f5_reg.lo_y;
        f6_next.mv   = f5_reg.mv;
        f6_next.xm   = f5_reg.xm;
        f6_next.ym   = f5_reg.ym;
        if (on_ground)
        begin
            f6_next.vx = f5_reg.fstop ? 32'sd0 : f5_reg.vx_fm;
            f6_next.xm = f5_reg.xm & ~f5_reg.fstop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f3_reg <= f3_next;
            f4_reg <= f4_next;
            f5_reg <= f5_next;
            f6_reg <= f6_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f3_vld_reg <= 1'b0;
            f4_vld_reg <= 1'b0;
            f5_vld_reg <= 1'b0;
            f6_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f3_vld_reg <= in_vld;
            f4_vld_reg <= f3_vld_reg;
            f5_vld_reg <= f4_vld_reg;
            f6_vld_reg <= f5_vld_reg;
        end
    end

    assign out_vld = f6_vld_reg;
    assign out_flr = f6_reg;

    // A body that sank below its ground leaves the snap stage exactly on it.
    a_floor_snap: assert property (@(posedge clk) disable iff (!rst_n)
        (f4_vld_reg && en && hit) |=> (f5_reg.py == f5_reg.ground))
        else $error("floor snap did not place the body on its ground");

endmodule

FILE: design/bms_walls.sv
// Wall stages: two reflection passes against the window edges on both axes.
`timescale 1ns / 1ps

module bms_walls (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  bms_pkg::cfg_t cfg,
    input  logic          in_vld,
    input  bms_pkg::flr_t in_flr,
    output logic          out_vld,
    output bms_pkg::res_t out_res
);

    typedef struct packed {
        logic signed [50:0] mx_p;
        logic signed [50:0] my_p;
        bms_pkg::flr_t      f;
    } wp_t;

    wp_t           w1_reg, w1_next, w3_reg, w3_next;
    bms_pkg::flr_t w2_reg, w2_next;
    bms_pkg::res_t w4_reg, w4_next;
    logic          w1_vld_reg, w2_vld_reg, w3_vld_reg, w4_vld_reg;
    logic          fire_hx, fire_hy, fire_lx, fire_ly;

    always_comb
    begin
        w1_next.mx_p = bms_pkg::neg33(in_flr.vx) * $signed({1'b0, cfg.restitution});
        w1_next.my_p = bms_pkg::neg33(in_flr.vy) * $signed({1'b0, cfg.restitution});
        w1_next.f    = in_flr;
    end

    always_comb
    begin
        fire_hx = w1_reg.f.mv && ($signed(w1_reg.f.px) >= $signed(w1_reg.f.hi_x))
               && ($signed(w1_reg.f.vx) > 32'sd0);
        fire_hy = w1_reg.f.mv && ($signed(w1_reg.f.py) >= $signed(w1_reg.f.hi_y))
               && ($signed(w1_reg.f.vy) > 32'sd0);
        w2_next = w1_reg.f;
        if (fire_hx)
        begin
            w2_next.px = w1_reg.f.hi_x;
            w2_next.vx = bms_pkg::qmul_sat({{13{w1_reg.mx_p[50]}}, w1_reg.mx_p});
        end
        if (fire_hy)
        begin
            w2_next.py = w1_reg.f.hi_y;
            w2_next.vy = bms_pkg::qmul_sat({{13{w1_reg.my_p[50]}}, w1_reg.my_p});
        end
    end

    always_comb
    begin
        w3_next.mx_p = bms_pkg::neg33(w2_reg.vx) * $signed({1'b0, cfg.restitution});
        w3_next.my_p = bms_pkg::neg33(w2_reg.vy) * $signed({1'b0, cfg.restitution});
        w3_next.f    = w2_reg;
    end

    always_comb
    begin
        fire_lx = w3_reg.f.mv && ($signed(w3_reg.f.px) <= $signed(w3_reg.f.lo_x))
               && ($signed(w3_reg.f.vx) < 32'sd0);
        fire_ly = w3_reg.f.mv && ($signed(w3_reg.f.py) <= $signed(w3_reg.f.lo_y))
               && ($signed(w3_reg.f.vy) < 32'sd0);
        w4_next.px = fire_lx ? w3_reg.f.lo_x : w3_reg.f.px;
        w4_next.vx = fire_lx ? bms_pkg::qmul_sat({{13{w3_reg.mx_p[50]}}, w3_reg.mx_p})
                             : w3_reg.f.vx;
        w4_next.py = fire_ly ? w3_reg.f.lo_y : w3_reg.f.py;
        w4_next.vy = fire_ly ? bms_pkg::qmul_sat({{13{w3_reg.my_p[50]}}, w3_reg.my_p})
                             : w3_reg.f.vy;
        w4_next.mv = w3_reg.f.mv & (w3_reg.f.xm | w3_reg.f.ym);
        w4_next.xm = w3_reg.f.xm;
        w4_next.ym = w3_reg.f.ym;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg <= w1_next;
            w2_reg <= w2_next;
            w3_reg <= w3_next;
            w4_reg <= w4_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_vld_reg <= 1'b0;
            w2_vld_reg <= 1'b0;
            w3_vld_reg <= 1'b0;
            w4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            w1_vld_reg <= in_vld;
            w2_vld_reg <= w1_vld_reg;
            w3_vld_reg <= w2_vld_reg;
            w4_vld_reg <= w3_vld_reg;
        end
    end

    assign out_vld = w4_vld_reg;
    assign out_res = w4_reg;

    // A reflection off the right wall can never leave a rightward speed.
    a_right_reflect: assert property (@(posedge clk) disable iff (!rst_n)
        (w1_vld_reg && en && fire_hx) |=> ($signed(w2_reg.vx) <= 32'sd0))
        else $error("right wall reflection left a positive horizontal speed");

endmodule

FILE: design/body_motion_step_unit.sv
// Top level of the body motion step unit: configuration registers, stream ports and pipeline.
`timescale 1ns / 1ps

// One explicit Euler step with floor bounce, ground friction and wall reflection per body.
// Bodies arrive as beats on the s_axis channel and leave as beats on the m_axis channel,
// one result beat for every input beat and in the same order.
// The datapath is a ten-stage pipeline: two kinematics stages, four floor stages and
// four wall stages, the last of which is the output register. Without back-pressure one
// beat is taken per cycle.
// The depth is set by the chain of dependent multiplications: gravity before vertical
// integration, and two wall reflections in turn, each with a register after it.
// When the receiver holds m_axis_tready low with a result waiting, the whole pipeline
// holds and s_axis_tready falls in the same cycle; nothing is lost or repeated.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata, one register per
// cycle, and must only change while the pipeline is empty.
// Reset clears all valid bits and restores the configuration registers to their default values.

module body_motion_step_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, vel_x, vel_y, point_size, moving, x_moving, y_moving, time_step
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // new_pos_x, new_pos_y, new_vel_x, new_vel_y, new_moving, new_x_moving, new_y_moving
    output logic [135:0] m_axis_tdata,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    bms_pkg::cfg_t  cfg_reg;
    bms_pkg::body_t in_body;
    bms_pkg::kin_t  kin;
    bms_pkg::flr_t  flr;
    bms_pkg::res_t  res;
    logic           en, kin_vld, flr_vld, res_vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gravity      <= 31'd655360;
            cfg_reg.restitution  <= 17'd52429;
            cfg_reg.friction     <= 31'd65536;
            cfg_reg.floor_level  <= -32'sd65536;
            cfg_reg.recip_width  <= 17'd82;
            cfg_reg.recip_height <= 17'd109;
        end
        else if (cfg_wr_en)
        begin
            case (bms_pkg::cfg_idx_t'(cfg_index))
                bms_pkg::IDX_GRAVITY:      cfg_reg.gravity      <= cfg_wdata[30:0];
                bms_pkg::IDX_RESTITUTION:  cfg_reg.restitution  <= cfg_wdata[16:0];
                bms_pkg::IDX_FRICTION:     cfg_reg.friction     <= cfg_wdata[30:0];
                bms_pkg::IDX_FLOOR_LEVEL:  cfg_reg.floor_level  <= cfg_wdata;
                bms_pkg::IDX_RECIP_WIDTH:  cfg_reg.recip_width  <= cfg_wdata[16:0];
                bms_pkg::IDX_RECIP_HEIGHT: cfg_reg.recip_height <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    assign in_body.px   = s_axis_tdata[31:0];
    assign in_body.py   = s_axis_tdata[63:32];
    assign in_body.vx   = s_axis_tdata[95:64];
    assign in_body.vy   = s_axis_tdata[127:96];
    assign in_body.size = s_axis_tdata[139:128];
    assign in_body.mv   = s_axis_tdata[140];
    assign in_body.xm   = s_axis_tdata[141];
    assign in_body.ym   = s_axis_tdata[142];
    assign in_body.dt   = s_axis_tdata[159:143];

    assign en            = !res_vld || m_axis_tready;
    assign s_axis_tready = en;

    bms_kin u_kin (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .cfg     (cfg_reg),
        .in_vld  (s_axis_tvalid),
        .in_body (in_body),
        .out_vld (kin_vld),
        .out_kin (kin)
    );

    bms_floor u_floor (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .cfg     (cfg_reg),
        .in_vld  (kin_vld),
        .in_kin  (kin),
        .out_vld (flr_vld),
        .out_flr (flr)
    );

    bms_walls u_walls (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .cfg     (cfg_reg),
        .in_vld  (flr_vld),
        .in_flr  (flr),
        .out_vld (res_vld),
        .out_res (res)
    );

    assign m_axis_tvalid = res_vld;
    assign m_axis_tdata  = {5'd0, res.ym, res.xm, res.mv, res.vy, res.vx, res.py, res.px};

    // A body still marked as moving must keep at least one axis in motion.
    a_motion_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (!res.mv || res.xm || res.ym))
        else $error("moving body with both axes stopped");

    a_cfg_gravity: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr_en && (cfg_index == bms_pkg::IDX_GRAVITY))
        |=> (cfg_reg.gravity == $past(cfg_wdata[30:0])))
        else $error("gravity register did not take the written value");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking stream testbench of the body motion step unit with its own Euler step predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int SEGMENTS       = 6;
    localparam int SEGMENT_BODIES = 170;
    localparam int HOLD_CYCLES    = 300;
    localparam int QUIET_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 20;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // pos_x, pos_y, vel_x, vel_y, point_size, moving, x_moving, y_moving, time_step
    logic [159:0] s_axis_tdata  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // new_pos_x, new_pos_y, new_vel_x, new_vel_y, new_moving, new_x_moving, new_y_moving
    logic [135:0] m_axis_tdata;
    logic         cfg_wr_en     = 1'b0;
    logic [2:0]   cfg_index     = '0;
    logic [31:0]  cfg_wdata     = '0;

    bms_pkg::cfg_t  regs;
    bms_pkg::body_t pending_bodies[$];
    bms_pkg::res_t  predicted_steps[$];
    bms_pkg::body_t offered;
    int    items_taken  = 0;
    int    results_seen = 0;
    int    error_count  = 0;
    int    quiet_cycles = 0;
    int    tx_idle_pct  = 18;
    int    rx_idle_pct  = 73;
    bit    hold_armed   = 1'b0;
    bit    hold_done    = 1'b0;
    int    hold_left    = 0;

    body_motion_step_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int clamp32(longint v);
        if (v > longint'(bms_pkg::S32_MAX))
            return bms_pkg::S32_MAX;
        if (v < longint'(bms_pkg::S32_MIN))
            return bms_pkg::S32_MIN;
        return int'(v);
    endfunction

    function automatic int q_product(longint a, longint b);
        return clamp32((a * b) >>> 16);
    endfunction

    function automatic int rnd_range(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic void wall_bounce(inout int pos, inout int vel, input longint half,
                                        input longint rest);
        int hi;
        int lo;
        hi = clamp32(longint'(bms_pkg::Q_ONE) - half);
        lo = clamp32(half - longint'(bms_pkg::Q_ONE));
        if (pos >= hi && vel > 0)
        begin
            pos = hi;
            vel = q_product(-longint'(vel), rest);
        end
        if (pos <= lo && vel < 0)
        begin
            pos = lo;
            vel = q_product(-longint'(vel), rest);
        end
    endfunction

    function automatic bms_pkg::res_t euler_step(bms_pkg::body_t b, bms_pkg::cfg_t c);
        bms_pkg::res_t r;
        int     px;
        int     py;
        int     vx;
        int     vy;
        int     ground;
        bit     mv;
        bit     xm;
        bit     ym;
        longint half_w;
        longint half_h;
        longint dt;
        longint rest;
        px = b.px;
        py = b.py;
        vx = b.vx;
        vy = b.vy;
        mv = b.mv;
        xm = b.xm;
        ym = b.ym;
        dt = longint'(b.dt);
        rest = longint'(c.restitution);
        if (mv)
        begin
            half_w = longint'(b.size) * longint'(c.recip_width);
            half_h = longint'(b.size) * longint'(c.recip_height);
            ground = clamp32(longint'(c.floor_level) + half_h);
            vy = clamp32(longint'(vy) - longint'(q_product(longint'(c.gravity), dt)));
            px = clamp32(longint'(px) + longint'(q_product(longint'(vx), dt)));
            py = clamp32(longint'(py) + longint'(q_product(longint'(vy), dt)));
            if (py < ground)
            begin
                py = ground;
                if (vy <= 0)
                begin
                    vy = q_product(-longint'(vy), rest);
                    if (vy >= -bms_pkg::BOUNCE_STOP && vy <= bms_pkg::BOUNCE_STOP)
                    begin
                        vy = 0;
                        ym = 1'b0;
                    end
                end
            end
            if (py == ground && vy == 0 && vx != 0)
            begin
                if (vx > 0)
                    vx = clamp32(longint'(vx) - longint'(q_product(longint'(c.friction), dt)));
                else
                    vx = clamp32(longint'(vx) + longint'(q_product(longint'(c.friction), dt)));
                if (vx >= -bms_pkg::SLIDE_STOP && vx <= bms_pkg::SLIDE_STOP)
                begin
                    vx = 0;
                    xm = 1'b0;
                end
            end
            wall_bounce(px, vx, half_w, rest);
            wall_bounce(py, vy, half_h, rest);
            if (!xm && !ym)
                mv = 1'b0;
        end
        r.px = px;
        r.py = py;
        r.vx = vx;
        r.vy = vy;
        r.mv = mv;
        r.xm = xm;
        r.ym = ym;
        return r;
    endfunction

    function automatic logic [159:0] pack_body(bms_pkg::body_t b);
        return {b.dt, b.ym, b.xm, b.mv, b.size, b.vy, b.vx, b.py, b.px};
    endfunction

    function automatic bms_pkg::body_t make_body(int px, int py, int vx, int vy, int size,
                                                 bit mv, bit xm, bit ym, int dt);
        bms_pkg::body_t b;
        b.px = px;
        b.py = py;
        b.vx = vx;
        b.vy = vy;
        b.size = 12'(size);
        b.mv = mv;
        b.xm = xm;
        b.ym = ym;
        b.dt = 17'(dt);
        return b;
    endfunction

    // Half of the bodies are placed near the floor or a wall under the current registers so that
    // bounces, settling, friction and reflections are reached; a fifth are raw bit patterns.
    function automatic bms_pkg::body_t random_body();
        bms_pkg::body_t b;
        int     kind;
        int     edge_pos;
        longint half;
        kind = $urandom_range(0, 9);
        b.px = rnd_range(-70000, 70000);
        b.py = rnd_range(-70000, 70000);
        b.vx = rnd_range(-300000, 300000);
        b.vy = rnd_range(-300000, 300000);
        b.size = 12'($urandom_range(0, 80));
        b.mv = ($urandom_range(0, 9) != 0);
        b.xm = ($urandom_range(0, 7) != 0);
        b.ym = ($urandom_range(0, 7) != 0);
        b.dt = 17'($urandom_range(0, 4369));
        case (kind)
            0, 1:
            begin
                b.px = $urandom;
                b.py = $urandom;
                b.vx = $urandom;
                b.vy = $urandom;
                b.size = 12'($urandom);
                b.mv = 1'($urandom);
                b.xm = 1'($urandom);
                b.ym = 1'($urandom);
                b.dt = 17'($urandom);
            end
            2, 3, 4:
            begin
                half = longint'(b.size) * longint'(regs.recip_height);
                b.py = clamp32(longint'(regs.floor_level) + half + rnd_range(-3000, 200));
                b.vy = rnd_range(-4000, 1000);
                if ($urandom_range(0, 1) != 0)
                    b.vx = rnd_range(-12000, 12000);
                else
                    b.vx = rnd_range(-80000, 80000);
                b.dt = 17'($urandom_range(0, 600));
            end
            5, 6:
            begin
                if ($urandom_range(0, 1) != 0)
                begin
                    half = longint'(b.size) * longint'(regs.recip_width);
                    edge_pos = clamp32(longint'(bms_pkg::Q_ONE) - half
                                       + rnd_range(-2000, 2000));
                    if ($urandom_range(0, 1) != 0)
                    begin
                        b.px = edge_pos;
                        b.vx = rnd_range(0, 200000);
                    end
                    else
                    begin
                        b.px = -edge_pos;
                        b.vx = rnd_range(-200000, 0);
                    end
                end
                else
                begin
                    half = longint'(b.size) * longint'(regs.recip_height);
                    edge_pos = clamp32(longint'(bms_pkg::Q_ONE) - half
                                       + rnd_range(-2000, 2000));
                    b.py = edge_pos;
                    b.vy = rnd_range(0, 400000);
                end
                b.dt = 17'($urandom_range(0, 2000));
            end
            default:
            begin
            end
        endcase
        return b;
    endfunction

    task automatic queue_body(bms_pkg::body_t b);
        pending_bodies.insert(pending_bodies.size(), b);
    endtask

    task automatic program_reg(bms_pkg::cfg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            bms_pkg::IDX_GRAVITY:      regs.gravity = value[30:0];
            bms_pkg::IDX_RESTITUTION:  regs.restitution = value[16:0];
            bms_pkg::IDX_FRICTION:     regs.friction = value[30:0];
            bms_pkg::IDX_FLOOR_LEVEL:  regs.floor_level = value;
            bms_pkg::IDX_RECIP_WIDTH:  regs.recip_width = value[16:0];
            bms_pkg::IDX_RECIP_HEIGHT: regs.recip_height = value[16:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic apply_setting(int seg);
        case (seg)
            1:
            begin
                program_reg(bms_pkg::IDX_GRAVITY, 32'hFFFF_FFFF);
                program_reg(bms_pkg::IDX_RESTITUTION, 32'd65536);
                program_reg(bms_pkg::IDX_FRICTION, 32'hFFFF_FFFF);
                program_reg(bms_pkg::IDX_FLOOR_LEVEL, 32'h7FFF_FFFF);
                program_reg(bms_pkg::IDX_RECIP_WIDTH, 32'd65536);
                program_reg(bms_pkg::IDX_RECIP_HEIGHT, 32'd65536);
            end
            2:
            begin
                program_reg(bms_pkg::IDX_GRAVITY, 32'd0);
                program_reg(bms_pkg::IDX_RESTITUTION, 32'd0);
                program_reg(bms_pkg::IDX_FRICTION, 32'd0);
                program_reg(bms_pkg::IDX_FLOOR_LEVEL, 32'h8000_0000);
                program_reg(bms_pkg::IDX_RECIP_WIDTH, 32'd0);
                program_reg(bms_pkg::IDX_RECIP_HEIGHT, 32'd0);
            end
            3:
            begin
                program_reg(bms_pkg::IDX_GRAVITY, $urandom);
                program_reg(bms_pkg::IDX_RESTITUTION, 32'h0001_FFFF);
                program_reg(bms_pkg::IDX_FRICTION, $urandom);
                program_reg(bms_pkg::IDX_FLOOR_LEVEL, $urandom);
                program_reg(bms_pkg::IDX_RECIP_WIDTH, 32'h0001_FFFF);
                program_reg(bms_pkg::IDX_RECIP_HEIGHT, 32'h0001_FFFF);
            end
            4:
            begin
                program_reg(bms_pkg::IDX_GRAVITY, $urandom_range(0, 32'h0100_0000));
                program_reg(bms_pkg::IDX_RESTITUTION, $urandom_range(0, 65536));
                program_reg(bms_pkg::IDX_FRICTION, $urandom_range(0, 32'h0010_0000));
                program_reg(bms_pkg::IDX_FLOOR_LEVEL, rnd_range(-131072, 65536));
                program_reg(bms_pkg::IDX_RECIP_WIDTH, $urandom_range(0, 2048));
                program_reg(bms_pkg::IDX_RECIP_HEIGHT, $urandom_range(0, 2048));
            end
            default:
            begin
                program_reg(bms_pkg::IDX_GRAVITY, 32'd655360);
                program_reg(bms_pkg::IDX_RESTITUTION, 32'd52429);
                program_reg(bms_pkg::IDX_FRICTION, 32'd65536);
                program_reg(bms_pkg::IDX_FLOOR_LEVEL, 32'hFFFF_0000);
                program_reg(bms_pkg::IDX_RECIP_WIDTH, 32'd82);
                program_reg(bms_pkg::IDX_RECIP_HEIGHT, 32'd109);
            end
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_for_drain();
        do
            @(posedge clk);
        while (pending_bodies.size() != 0 || s_axis_tvalid || results_seen != items_taken);
    endtask

    task automatic compare_field(string name, longint got, longint want);
        if (got != want)
        begin
            $display("tb: result %0d field %s is %0d, predicted %0d",
                     results_seen, name, got, want);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted_steps.insert(predicted_steps.size(), euler_step(offered, regs));
                items_taken <= items_taken + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_bodies.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    offered = pending_bodies.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pack_body(offered);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_armed && !hold_done && s_axis_tvalid)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin : monitor
        bms_pkg::res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (results_seen >= items_taken)
            begin
                $display("tb: result beat arrived with no body outstanding");
                error_count++;
            end
            else
            begin
                want = predicted_steps.pop_front();
                compare_field("new_pos_x", signed'(m_axis_tdata[31:0]), want.px);
                compare_field("new_pos_y", signed'(m_axis_tdata[63:32]), want.py);
                compare_field("new_vel_x", signed'(m_axis_tdata[95:64]), want.vx);
                compare_field("new_vel_y", signed'(m_axis_tdata[127:96]), want.vy);
                compare_field("new_moving", m_axis_tdata[128], want.mv);
                compare_field("new_x_moving", m_axis_tdata[129], want.xm);
                compare_field("new_y_moving", m_axis_tdata[130], want.ym);
                results_seen <= results_seen + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int seg;
        regs.gravity = 31'd655360;
        regs.restitution = 17'd52429;
        regs.friction = 31'd65536;
        regs.floor_level = -32'sd65536;
        regs.recip_width = 17'd82;
        regs.recip_height = 17'd109;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Under the reset registers a ten pixel body has its ground at -64446 and its side
        // walls at plus and minus 64716.
        queue_body(make_body(123456, -98765, 4321, -1234, 33, 0, 1, 1, 1092));
        queue_body(make_body(bms_pkg::S32_MAX, bms_pkg::S32_MIN, bms_pkg::S32_MIN,
                             bms_pkg::S32_MAX, 4095, 0, 0, 0, 131071));
        queue_body(make_body(0, 0, 0, 0, 0, 1, 1, 1, 0));
        queue_body(make_body(0, 0, 30000, 0, 10, 1, 1, 1, 1092));
        queue_body(make_body(0, -64000, 0, -200000, 10, 1, 1, 1, 1092));
        queue_body(make_body(0, -64451, 20000, -1000, 10, 1, 1, 1, 0));
        queue_body(make_body(0, -64451, 50000, 0, 10, 1, 1, 0, 16));
        queue_body(make_body(0, -64451, -50000, 0, 10, 1, 1, 0, 16));
        queue_body(make_body(0, -64451, 9000, 0, 10, 1, 1, 0, 16));
        queue_body(make_body(64816, 0, 100000, 0, 10, 1, 1, 1, 0));
        queue_body(make_body(-64816, 0, -100000, 0, 10, 1, 1, 1, 0));
        queue_body(make_body(0, 64500, 0, 50000, 10, 1, 1, 1, 0));
        queue_body(make_body(0, 0, 70000, 0, 4095, 1, 1, 1, 0));
        queue_body(make_body(bms_pkg::S32_MAX, 0, bms_pkg::S32_MAX, 0, 0, 1, 1, 1, 65536));
        queue_body(make_body(bms_pkg::S32_MIN, bms_pkg::S32_MIN, bms_pkg::S32_MIN,
                             bms_pkg::S32_MIN, 0, 1, 1, 1, 131071));
        queue_body(make_body(0, -70000, 0, bms_pkg::S32_MIN, 0, 1, 1, 1, 0));
        queue_body(make_body(1000, 1000, 0, 0, 5, 1, 0, 0, 100));
        queue_body(make_body(1000, 1000, 500, 0, 5, 1, 0, 1, 100));
        queue_body(make_body(0, 30000, -20000, 10000, 2048, 1, 1, 1, 131071));
        queue_body(make_body(0, -66000, 0, 500000, 0, 1, 1, 1, 0));
        wait_for_drain();

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            tx_idle_pct = (seg < 2) ? 18 : (seg < 4) ? 73 : 0;
            rx_idle_pct = (seg < 2) ? 73 : (seg < 4) ? 18 : 0;
            hold_armed = (seg == 4);
            apply_setting(seg);
            repeat (SEGMENT_BODIES) queue_body(random_body());
            wait_for_drain();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d bodies stepped under %0d register settings, %0d mismatches",
                 items_taken, SEGMENTS + 1, error_count);
        $display("tb: output held off once for %0d cycles while bodies kept arriving",
                 HOLD_CYCLES);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
